@@ src/prti_pkg.sv @@
package prti_pkg;

  localparam int POS_W  = 48;
  localparam int RATE_W = 32;
  localparam int TGT_W  = 64;
  localparam int ANS_W  = 64;
  localparam int ACC_W  = 128;
  localparam int ENT_W  = POS_W + RATE_W;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_FRAC_BITS    = 16;

  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_APPEND = 3'd1;
  localparam logic [2:0] FN_INTEG  = 3'd2;
  localparam logic [2:0] FN_INVERT = 3'd3;
  localparam logic [2:0] FN_RATE   = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_ORDER = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  typedef struct packed {
    logic                    sat;
    logic [ANS_W-1:0]        val;
  } sat_res_t;

  function automatic sat_res_t sat64(input logic signed [ACC_W-1:0] v);
    sat_res_t r;
    if ((&v[ACC_W-1:ANS_W-1]) || !(|v[ACC_W-1:ANS_W-1])) begin
      r.sat = 1'b0;
      r.val = v[ANS_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = v[ACC_W-1] ? {1'b1, {(ANS_W-1){1'b0}}} : {1'b0, {(ANS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ src/prti_div.sv @@
module prti_div
  import prti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic signed [ACC_W-1:0]  dividend,
  input  logic signed [RATE_W-1:0] divisor,
  output logic                     done,
  output logic [ACC_W-1:0]         quotient
);

  localparam int SW = $clog2(ACC_W);

  logic              busy_r;
  logic              done_r;
  logic [SW-1:0]     cnt_r;
  logic [ACC_W-1:0]  dq_r;
  logic [RATE_W-1:0] rem_r;
  logic [RATE_W-1:0] dvs_r;
  logic [RATE_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, dq_r[ACC_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dq_r   <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
        dvs_r  <= divisor[RATE_W-1] ? RATE_W'(-divisor) : RATE_W'(divisor);
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? RATE_W'(trial - {1'b0, dvs_r}) : trial[RATE_W-1:0];
        dq_r  <= {dq_r[ACC_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

@@ src/piecewise_rate_table_integrator.sv @@
// channel | ports                  | contents
// in      | in_tvalid/tready/tdata | tdata: position, rate, target; tuser: func
// out     | out_tvalid/tready/tdata| tdata: answer; tuser: status
// Clear, append, empty queries and unused codes go straight to the result state.
// Rate walks each entry through S_RD and S_CHK; integrate and inverse add S_ML,
// S_MH, S_SUM and S_APP, the inverse then the bit-serial divider. Each integrate
// or inverse entry costs a table read and two 25x32 partial products, one per cycle.
// Reset (rst_n low, synchronous) empties the table; the memory is not cleared.
// A waiting result does not block the next input word; a new result waits for it.
module piecewise_rate_table_integrator
  import prti_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // position[47:0], rate[79:48], target[143:80]
  input  logic [2:0]   in_tuser,   // func[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // answer[63:0]
  output logic [2:0]   out_tuser   // status[2:0]
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int MW = 25;
  localparam int PW = MW + RATE_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_ML   = 4'd3;
  localparam logic [3:0] S_MH   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_APP  = 4'd6;
  localparam logic [3:0] S_DGO  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_QADD = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]               state_r;
  logic [CW-1:0]            cnt_r;
  logic [AW-1:0]            idx_r;
  logic [2:0]               func_r;
  logic signed [POS_W-1:0]  pos_r;
  logic signed [ACC_W-1:0]  goal_r;
  logic signed [POS_W-1:0]  last_s_r;
  logic signed [POS_W-1:0]  prev_s_r;
  logic signed [RATE_W-1:0] prev_r_r;
  logic signed [POS_W-1:0]  cur_s_r;
  logic signed [RATE_W-1:0] cur_r_r;
  logic signed [POS_W:0]    mul_a_r;
  logic signed [PW-1:0]     prod_lo_r;
  logic signed [PW-1:0]     prod_hi_r;
  logic signed [ACC_W-1:0]  seg_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  dvd_r;
  logic signed [RATE_W-1:0] dvs_r;
  logic signed [ACC_W-1:0]  q_r;
  logic signed [POS_W-1:0]  base_s_r;
  logic                     final_r;
  logic                     qneg_r;
  logic                     div_go_r;
  logic [ANS_W-1:0]         pend_ans_r;
  logic [2:0]               pend_st_r;
  logic                     out_valid_r;
  logic [ANS_W-1:0]         out_ans_r;
  logic [2:0]               out_st_r;

  logic [ENT_W-1:0]         seg_mem [MAX_SEGMENTS];
  logic [ENT_W-1:0]         rd_r;

  logic [2:0]               in_func;
  logic signed [POS_W-1:0]  in_pos;
  logic signed [RATE_W-1:0] in_rate;
  logic signed [TGT_W-1:0]  in_tgt;
  logic                     in_acc;
  logic                     room;
  logic                     wr_en;
  logic signed [POS_W-1:0]  e_s;
  logic signed [RATE_W-1:0] e_r;
  logic                     e_le;
  logic signed [ACC_W-1:0]  sum;
  logic                     goal_le;
  logic                     adv_go;
  logic signed [POS_W-1:0]  np_s;
  logic signed [RATE_W-1:0] np_r;
  logic                     has_next;
  logic                     div_done;
  logic [ACC_W-1:0]         div_q;
  sat_res_t                 sat_int;
  sat_res_t                 sat_inv;

  assign in_func = in_tuser;
  assign in_pos  = in_tdata[POS_W-1:0];
  assign in_rate = in_tdata[POS_W+RATE_W-1:POS_W];
  assign in_tgt  = in_tdata[POS_W+RATE_W+TGT_W-1:POS_W+RATE_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign room      = cnt_r < CW'(MAX_SEGMENTS);
  assign wr_en     = in_acc && (in_func == FN_APPEND) && room &&
                     !((cnt_r != '0) && (in_pos <= last_s_r));

  assign e_s      = rd_r[POS_W-1:0];
  assign e_r      = rd_r[ENT_W-1:POS_W];
  assign e_le     = e_s <= pos_r;
  assign sum      = acc_r + seg_r;
  assign goal_le  = goal_r <= sum;
  assign has_next = ({1'b0, idx_r} + 1'b1) < (AW+1)'(cnt_r);
  assign np_s     = (state_r == S_APP) ? cur_s_r : e_s;
  assign np_r     = (state_r == S_APP) ? cur_r_r : e_r;
  assign adv_go   = ((state_r == S_CHK) &&
                     ((idx_r == '0) || ((func_r == FN_RATE) && e_le))) ||
                    ((state_r == S_APP) && !final_r &&
                     !((func_r == FN_INVERT) && goal_le));
  assign sat_int  = sat64(sum >>> FRAC_BITS);
  assign sat_inv  = sat64(ACC_W'(base_s_r) + q_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[cnt_r[AW-1:0]] <= {in_rate, in_pos};
    end
    rd_r <= seg_mem[idx_r];
  end

  prti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r     <= in_func;
            pos_r      <= in_pos;
            goal_r     <= ACC_W'(in_tgt) <<< FRAC_BITS;
            acc_r      <= '0;
            idx_r      <= '0;
            pend_ans_r <= '0;
            pend_st_r  <= ST_OK;
            state_r    <= S_FIN;
            case (in_func)
              FN_CLEAR: begin
                cnt_r <= '0;
              end
              FN_APPEND: begin
                if (!room) begin
                  pend_st_r <= ST_FULL;
                end else if (!wr_en) begin
                  pend_st_r <= ST_ORDER;
                end else begin
                  cnt_r    <= cnt_r + 1'b1;
                  last_s_r <= in_pos;
                end
              end
              FN_INTEG, FN_INVERT, FN_RATE: begin
                if (cnt_r == '0) begin
                  pend_st_r  <= ST_EMPTY;
                  pend_ans_r <= (in_func == FN_RATE) ? '1 : '0;
                end else begin
                  state_r <= S_RD;
                end
              end
              default: begin
                pend_st_r <= ST_OK;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (idx_r != '0) begin
            case (func_r)
              FN_INTEG: begin
                cur_s_r <= e_s;
                cur_r_r <= e_r;
                state_r <= S_ML;
                if (e_le) begin
                  mul_a_r <= (POS_W+1)'(e_s) - (POS_W+1)'(prev_s_r);
                  final_r <= 1'b0;
                end else begin
                  mul_a_r <= (POS_W+1)'(pos_r) - (POS_W+1)'(prev_s_r);
                  final_r <= 1'b1;
                end
              end
              FN_INVERT: begin
                cur_s_r <= e_s;
                cur_r_r <= e_r;
                mul_a_r <= (POS_W+1)'(e_s) - (POS_W+1)'(prev_s_r);
                final_r <= 1'b0;
                state_r <= S_ML;
              end
              default: begin
                if (!e_le) begin
                  pend_ans_r <= ANS_W'(prev_r_r);
                  state_r    <= S_FIN;
                end
              end
            endcase
          end
        end
        S_ML: begin
          prod_lo_r <= $signed({1'b0, mul_a_r[MW-2:0]}) * prev_r_r;
          state_r   <= S_MH;
        end
        S_MH: begin
          prod_hi_r <= $signed(mul_a_r[POS_W:MW-1]) * prev_r_r;
          state_r   <= S_SUM;
        end
        S_SUM: begin
          seg_r   <= (ACC_W'(prod_hi_r) <<< (MW-1)) + ACC_W'(prod_lo_r);
          state_r <= S_APP;
        end
        S_APP: begin
          if (func_r == FN_INTEG) begin
            acc_r <= sum;
            if (final_r) begin
              pend_ans_r <= sat_int.val;
              pend_st_r  <= sat_int.sat ? ST_SAT : ST_OK;
              state_r    <= S_FIN;
            end
          end else if (goal_le) begin
            if (prev_r_r == '0) begin
              pend_ans_r <= ANS_W'(cur_s_r);
              state_r    <= S_FIN;
            end else begin
              dvd_r    <= goal_r - acc_r;
              dvs_r    <= prev_r_r;
              base_s_r <= prev_s_r;
              state_r  <= S_DGO;
            end
          end else begin
            acc_r <= sum;
          end
        end
        S_DGO: begin
          div_go_r <= 1'b1;
          qneg_r   <= dvd_r[ACC_W-1] ^ dvs_r[RATE_W-1];
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            q_r     <= qneg_r ? ACC_W'(-div_q) : ACC_W'(div_q);
            state_r <= S_QADD;
          end
        end
        S_QADD: begin
          pend_ans_r <= sat_inv.val;
          pend_st_r  <= sat_inv.sat ? ST_SAT : ST_OK;
          state_r    <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_ans_r   <= pend_ans_r;
            out_st_r    <= pend_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (adv_go) begin
        prev_s_r <= np_s;
        prev_r_r <= np_r;
        if (has_next) begin
          idx_r   <= idx_r + 1'b1;
          state_r <= S_RD;
        end else begin
          case (func_r)
            FN_INTEG: begin
              mul_a_r <= (POS_W+1)'(pos_r) - (POS_W+1)'(np_s);
              final_r <= 1'b1;
              state_r <= S_ML;
            end
            FN_INVERT: begin
              if (np_r == '0) begin
                pend_ans_r <= ANS_W'(np_s);
                state_r    <= S_FIN;
              end else begin
                dvd_r    <= goal_r - ((state_r == S_APP) ? sum : acc_r);
                dvs_r    <= np_r;
                base_s_r <= np_s;
                state_r  <= S_DGO;
              end
            end
            default: begin
              pend_ans_r <= ANS_W'(np_r);
              state_r    <= S_FIN;
            end
          endcase
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ans_r;
  assign out_tuser  = out_st_r;

endmodule

@@ bench/tb_piecewise_rate_table_integrator.sv @@
module tb_piecewise_rate_table_integrator;
  import prti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = DEF_MAX_SEGMENTS;
  localparam int FB = DEF_FRAC_BITS;
  localparam logic [2:0] FN_SPARE5 = 3'd5;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic signed [47:0] POS_MIN = {1'b1, 47'd0};
  localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [31:0] RATE_MIN = {1'b1, 31'd0};
  localparam logic signed [31:0] RATE_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [63:0] TGT_MIN = {1'b1, 63'd0};
  localparam logic signed [63:0] TGT_MAX = {1'b0, {63{1'b1}}};

  typedef struct {
    logic [63:0] answer;
    logic [2:0]  status;
  } result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;

  result_t pending_results[$];
  logic signed [47:0] tbl_start[NSEG];
  logic signed [31:0] tbl_rate[NSEG];
  int tbl_count = 0;
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  bit hold_rx = 0;
  bit gaps_on = 1;

  piecewise_rate_table_integrator u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] clamp64(input logic signed [127:0] v, inout logic [2:0] st);
    if ((&v[127:63]) || !(|v[127:63])) return v[63:0];
    st = ST_SAT;
    return v[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic int seg_holding(input logic signed [47:0] pos);
    int idx = 0;
    for (int i = 0; i < tbl_count; i++) if (tbl_start[i] <= pos) idx = i;
    return idx;
  endfunction

  function automatic logic signed [127:0] seg_area(input int i, input logic signed [47:0] upto);
    logic signed [127:0] a, b, r;
    a = upto;
    b = tbl_start[i];
    r = tbl_rate[i];
    return (a - b) * r;
  endfunction

  function automatic result_t predict_table(input logic [2:0] fn, input logic signed [47:0] pos,
                                            input logic signed [31:0] rate,
                                            input logic signed [63:0] tgt);
    result_t res;
    logic signed [127:0] acc, goal, seg, rr, pos_w;
    int idx;
    bit done;
    res.answer = '0;
    res.status = ST_OK;
    if (fn == FN_CLEAR) begin
      tbl_count = 0;
    end else if (fn == FN_APPEND) begin
      if (tbl_count >= NSEG) res.status = ST_FULL;
      else if (tbl_count > 0 && pos <= tbl_start[tbl_count-1]) res.status = ST_ORDER;
      else begin
        tbl_start[tbl_count] = pos;
        tbl_rate[tbl_count] = rate;
        tbl_count++;
      end
    end else if (fn >= FN_INTEG && fn <= FN_RATE && tbl_count == 0) begin
      res.status = ST_EMPTY;
      res.answer = (fn == FN_RATE) ? '1 : '0;
    end else if (fn == FN_INTEG) begin
      if (pos <= tbl_start[0]) acc = seg_area(0, pos);
      else begin
        idx = seg_holding(pos);
        acc = 0;
        for (int i = 0; i < idx; i++) acc += seg_area(i, tbl_start[i+1]);
        acc += seg_area(idx, pos);
      end
      res.answer = clamp64(acc >>> FB, res.status);
    end else if (fn == FN_INVERT) begin
      goal = tgt;
      goal = goal <<< FB;
      acc = 0;
      done = 0;
      for (int i = 0; i < tbl_count - 1 && !done; i++) begin
        seg = seg_area(i, tbl_start[i+1]);
        if (goal <= acc + seg) begin
          rr = tbl_rate[i];
          if (tbl_rate[i] == 0) pos_w = tbl_start[i+1];
          else begin
            pos_w = tbl_start[i];
            pos_w = pos_w + (goal - acc) / rr;
          end
          done = 1;
        end else acc += seg;
      end
      if (!done) begin
        idx = tbl_count - 1;
        rr = tbl_rate[idx];
        pos_w = tbl_start[idx];
        if (tbl_rate[idx] != 0) pos_w = pos_w + (goal - acc) / rr;
      end
      res.answer = clamp64(pos_w, res.status);
    end else if (fn == FN_RATE) begin
      if (pos < tbl_start[0]) res.answer = 64'(tbl_rate[0]);
      else res.answer = 64'(tbl_rate[seg_holding(pos)]);
    end
    return res;
  endfunction

  task automatic send_word(input logic [2:0] fn, input logic signed [47:0] pos,
                           input logic signed [31:0] rate, input logic signed [63:0] tgt);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {tgt, rate, pos};
    in_tuser <= fn;
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), predict_table(fn, pos, rate, tgt));
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 8);
      end else burst_left--;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_rx = 0;
      end else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word answer=%h status=%0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.answer) begin
          $error("answer expected %h actual %h", want.answer, out_tdata);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [47:0] rand_pos();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic signed [63:0] rand_tgt();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_empty_table();
    send_word(FN_INTEG, POS_MAX, 0, 0);
    send_word(FN_INVERT, 0, 0, TGT_MIN);
    send_word(FN_RATE, POS_MIN, 0, 0);
    send_word(FN_SPARE5, POS_MAX, RATE_MAX, TGT_MAX);
    send_word(FN_SPARE6, 0, 0, 0);
    send_word(FN_SPARE7, POS_MIN, RATE_MIN, TGT_MIN);
  endtask

  task automatic test_append_rules();
    send_word(FN_CLEAR, 0, 0, 0);
    send_word(FN_APPEND, 48'sd1000, 32'sd65536, 0);
    send_word(FN_APPEND, 48'sd1000, 32'sd5, 0);
    send_word(FN_APPEND, 48'sd10, 32'sd5, 0);
    for (int i = 1; i < NSEG; i++) send_word(FN_APPEND, 48'sd1000 + i * 4096, $urandom(), 0);
    send_word(FN_APPEND, 48'sd5, 32'sd1, 0);
    send_word(FN_APPEND, POS_MAX, 32'sd1, 0);
    send_word(FN_INTEG, 48'sd1000 + 70 * 4096, 0, 0);
    send_word(FN_INVERT, 0, 0, 64'sd123456);
    send_word(FN_RATE, 48'sd1000 + 3 * 4096 + 7, 0, 0);
    drain_results();
  endtask

  task automatic test_extremes();
    send_word(FN_CLEAR, 0, 0, 0);
    send_word(FN_APPEND, POS_MIN, RATE_MAX, 0);
    send_word(FN_APPEND, 48'sd0, 32'sd0, 0);
    send_word(FN_APPEND, POS_MAX, RATE_MIN, 0);
    send_word(FN_INTEG, POS_MAX, 0, 0);
    send_word(FN_INTEG, POS_MIN, 0, 0);
    send_word(FN_INTEG, 48'sd100, 0, 0);
    send_word(FN_INVERT, 0, 0, TGT_MAX);
    send_word(FN_INVERT, 0, 0, TGT_MIN);
    send_word(FN_INVERT, 0, 0, 0);
    send_word(FN_RATE, POS_MIN, 0, 0);
    send_word(FN_RATE, POS_MAX, 0, 0);
    send_word(FN_CLEAR, 0, 0, 0);
    send_word(FN_APPEND, 48'sd65536, 32'sd1, 0);
    send_word(FN_INTEG, POS_MIN, 0, 0);
    send_word(FN_RATE, POS_MIN, 0, 0);
    send_word(FN_INVERT, 0, 0, TGT_MAX);
    send_word(FN_INVERT, 0, 0, TGT_MIN);
    drain_results();
  endtask

  task automatic run_table_session(input int nseg, input bit wide_vals);
    logic signed [47:0] s;
    logic signed [31:0] r;
    int nq;
    send_word(FN_CLEAR, 0, 0, 0);
    s = wide_vals ? rand_pos() >>> 4 : $signed(48'($urandom_range(0, 1 << 24))) - 48'sd8388608;
    for (int i = 0; i < nseg; i++) begin
      r = wide_vals ? $urandom() : $signed(32'($urandom_range(0, 1 << 20))) - 32'sd262144;
      if ($urandom_range(0, 7) == 0) r = 0;
      if ($urandom_range(0, 15) == 0) send_word(FN_APPEND, s - $urandom_range(0, 100), r, 0);
      send_word(FN_APPEND, s, r, 0);
      s = s + (wide_vals ? 48'($urandom_range(1, 1 << 30)) : 48'($urandom_range(1, 1 << 20)));
    end
    nq = $urandom_range(4, 12);
    for (int q = 0; q < nq; q++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_word(FN_INTEG, s - 48'($urandom_range(0, 1 << 22)), $urandom(), rand_tgt());
        3, 4, 5: send_word(FN_INVERT, rand_pos(), $urandom(),
                           wide_vals ? rand_tgt() : rand_tgt() >>> $urandom_range(16, 60));
        6, 7: send_word(FN_RATE, s - 48'($urandom_range(0, 1 << 22)), $urandom(), rand_tgt());
        8: send_word(3'($urandom_range(5, 7)), rand_pos(), $urandom(), rand_tgt());
        default: send_word(3'($urandom_range(2, 4)), rand_pos(), $urandom(), rand_tgt());
      endcase
    end
  endtask

  task automatic test_random_sessions(input int items);
    int sent0;
    sent0 = 0;
    while (sent0 < items) begin
      if ($urandom_range(0, 19) == 0) begin
        run_table_session(NSEG, $urandom_range(0, 1));
        sent0 += NSEG + 10;
      end else begin
        run_table_session($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        sent0 += 15;
      end
      if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
    end
    gaps_on = 1;
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_rx = 1;
    run_table_session(4, 0);
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_append_rules();
    test_extremes();
    test_backpressure();
    test_random_sessions(1400);
    drain_results();
    repeat (500) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
